[sv/tjpi_pkg.sv]
`timescale 1ns / 1ps
// tjpi_pkg: shared widths, reset values, limits and sequencer states for the
// three-joint pi position controller and its port checker; no dependencies
package tjpi_pkg;

    localparam int JOINTS_DEF  = 3;
    localparam int POS_W       = 32;   // signed q16.16 position
    localparam int ERR_W       = 33;   // exact position difference
    localparam int GAIN_W      = 16;   // unsigned q8.8 gains, q0.16 period
    localparam int MUL_B_W     = 17;   // gain with a zero sign bit
    localparam int PROD_W      = 50;   // ERR_W + MUL_B_W
    localparam int INTEG_W     = 21;   // integrator, within +-10.0
    localparam int SPEED_W     = 24;   // speed setpoint, within +-110.0
    localparam int CFG_DATA_W  = 16;   // widest register

    localparam logic [GAIN_W-1:0] KP_RESET     = 16'd256;
    localparam logic [GAIN_W-1:0] KI_RESET     = 16'd0;
    localparam logic [GAIN_W-1:0] PERIOD_RESET = 16'd655;
    localparam logic [7:0]        REVERSE_RESET = 8'd4;

    localparam int INTEG_LIMIT = 655360;
    localparam int SPEED_LIMIT = 7208960;

    // per-joint step sequence
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ERR    = 6'b000010,
        ST_MUL_P  = 6'b000100,
        ST_INTEG  = 6'b001000,
        ST_MUL_KI = 6'b010000,
        ST_SUM    = 6'b100000
    } state_t;

endpackage

[sv/three_joint_pi_position_controller.sv]
`timescale 1ns / 1ps
// three_joint_pi_position_controller: pi position loop for JOINTS joints with
// integrator clamp, output clamp and per-joint direction reversal
// depends on tjpi_pkg
//
// One input transfer carries a target and a measured position per joint
// (signed q16.16 degrees); one output transfer returns a speed setpoint per
// joint (signed q8.16, within +-110.0). For every joint the error
// target - measured is taken at full 33-bit precision, error * sample_period
// (floored to q16.16) is added to that joint's integrator, which saturates at
// +-10.0, and the setpoint kp*error + ki*integrator (floored to q16.16) is
// saturated at +-110.0 and negated where the joint's reverse_mask bit is set.
// A single 33x17 signed multiplier is shared by all products under a small
// sequencer: each joint steps through error, period product, integrator
// update with kp product, ki product, and sum and clamp. The input side is
// not ready while an item is at work or while its result waits for transfer.
// The user must write registers through the plain write port only while the
// block is idle; the block itself does not enforce this. The integrators
// reset to zero.
module three_joint_pi_position_controller
    import tjpi_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF,
    localparam int CFG_IDX_W = $clog2(2 * JOINTS + 2),
    localparam int JNT_W     = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fields from bit 0 up: target_joint1..JOINTS, measured_joint1..JOINTS
    input  logic [2*JOINTS*POS_W-1:0]       s_tdata,

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fields from bit 0 up: speed_joint1..JOINTS
    output logic [JOINTS*SPEED_W-1:0]       m_tdata,

    // register write port
    input  logic                            cfg_we,
    input  logic [CFG_IDX_W-1:0]            cfg_addr,
    input  logic [CFG_DATA_W-1:0]           cfg_wdata
);

    localparam logic [JOINTS-1:0] REV_RST  = REVERSE_RESET[JOINTS-1:0];
    localparam logic [JNT_W-1:0]  JNT_LAST = JNT_W'(JOINTS - 1);

    // configuration registers
    logic [GAIN_W-1:0]  kp_reg [JOINTS];
    logic [GAIN_W-1:0]  ki_reg [JOINTS];
    logic [GAIN_W-1:0]  period_reg;
    logic [JOINTS-1:0]  reverse_reg;

    // sequencer and datapath
    state_t                    state_reg, state_next;
    logic [JNT_W-1:0]          jnt_reg, jnt_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic signed [POS_W-1:0]   tgt_reg  [JOINTS];
    logic signed [POS_W-1:0]   meas_reg [JOINTS];
    logic signed [INTEG_W-1:0] integ_reg [JOINTS];
    logic signed [SPEED_W-1:0] spd_reg  [JOINTS];

    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  acc_reg;

    logic signed [ERR_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    logic signed [ERR_W+1:0]   integ_sum;    // integrator plus increment
    logic signed [INTEG_W-1:0] integ_sat;
    logic signed [PROD_W:0]    acc_sum;      // kp and ki products, q.24
    logic signed [PROD_W-8:0]  acc_shr;      // floored to q27.16
    logic signed [SPEED_W-1:0] spd_sat;
    logic signed [SPEED_W-1:0] spd_out;

    logic s_xfer;
    logic m_xfer;

    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid_reg && m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        for (int j = 0; j < JOINTS; j++) begin
            m_tdata[j*SPEED_W +: SPEED_W] = spd_reg[j];
        end
    end

    // register writes, out-of-range indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < JOINTS; j++) begin
                kp_reg[j] <= KP_RESET;
                ki_reg[j] <= KI_RESET;
            end
            period_reg  <= PERIOD_RESET;
            reverse_reg <= REV_RST;
        end else if (cfg_we) begin
            if (int'(cfg_addr) < JOINTS) begin
                kp_reg[JNT_W'(int'(cfg_addr))] <= cfg_wdata;
            end else if (int'(cfg_addr) < 2 * JOINTS) begin
                ki_reg[JNT_W'(int'(cfg_addr) - JOINTS)] <= cfg_wdata;
            end else if (int'(cfg_addr) == 2 * JOINTS) begin
                period_reg <= cfg_wdata;
            end else if (int'(cfg_addr) == 2 * JOINTS + 1) begin
                reverse_reg <= cfg_wdata[JOINTS-1:0];
            end
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = err_reg;
        mul_b = {1'b0, period_reg};
        unique case (state_reg)
            ST_INTEG:  mul_b = {1'b0, kp_reg[jnt_reg]};
            ST_MUL_KI: begin
                mul_a = ERR_W'(integ_reg[jnt_reg]);
                mul_b = {1'b0, ki_reg[jnt_reg]};
            end
            default:   mul_b = {1'b0, period_reg};
        endcase
    end

    // integrator update: floor(error*period / 2^16), then clamp
    always_comb begin
        integ_sum = (ERR_W+2)'(integ_reg[jnt_reg])
                  + (ERR_W+2)'($signed(prod_reg[PROD_W-1:16]));
        if (integ_sum > (ERR_W+2)'(INTEG_LIMIT)) begin
            integ_sat = INTEG_W'(INTEG_LIMIT);
        end else if (integ_sum < (ERR_W+2)'(-INTEG_LIMIT)) begin
            integ_sat = INTEG_W'(-INTEG_LIMIT);
        end else begin
            integ_sat = integ_sum[INTEG_W-1:0];
        end
    end

    // setpoint: sum, floor to q16.16, clamp, optional reversal
    always_comb begin
        acc_sum = (PROD_W+1)'(acc_reg) + (PROD_W+1)'(prod_reg);
        acc_shr = acc_sum[PROD_W:8];
        if (acc_shr > (PROD_W-7)'(SPEED_LIMIT)) begin
            spd_sat = SPEED_W'(SPEED_LIMIT);
        end else if (acc_shr < (PROD_W-7)'(-SPEED_LIMIT)) begin
            spd_sat = SPEED_W'(-SPEED_LIMIT);
        end else begin
            spd_sat = acc_shr[SPEED_W-1:0];
        end
        spd_out = reverse_reg[jnt_reg] ? -spd_sat : spd_sat;
    end

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        jnt_next      = jnt_reg;
        m_tvalid_next = m_tvalid_reg;
        err_next      = err_reg;
        prod_next     = prod_reg;
        if (m_xfer) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_ERR;
                    jnt_next   = '0;
                end
            end
            ST_ERR: begin
                err_next   = ERR_W'(tgt_reg[jnt_reg]) - ERR_W'(meas_reg[jnt_reg]);
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                prod_next  = mul_a * mul_b;         // error * period
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                prod_next  = mul_a * mul_b;         // error * kp
                state_next = ST_MUL_KI;
            end
            ST_MUL_KI: begin
                prod_next  = mul_a * mul_b;         // integrator * ki
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (jnt_reg == JNT_LAST) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end else begin
                    state_next = ST_ERR;
                    jnt_next   = jnt_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            jnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            jnt_reg      <= jnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // integrators start from zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < JOINTS; j++) begin
                integ_reg[j] <= '0;
            end
        end else if (state_reg == ST_INTEG) begin
            integ_reg[jnt_reg] <= integ_sat;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        err_reg  <= err_next;
        prod_reg <= prod_next;
        if (state_reg == ST_MUL_KI) begin
            acc_reg <= prod_reg;                    // keep kp product
        end
        if (s_xfer) begin
            for (int j = 0; j < JOINTS; j++) begin
                tgt_reg[j]  <= s_tdata[j*POS_W +: POS_W];
                meas_reg[j] <= s_tdata[(JOINTS+j)*POS_W +: POS_W];
            end
        end
        if (state_reg == ST_SUM) begin
            spd_reg[jnt_reg] <= spd_out;
        end
    end

endmodule

[sv/tjpi_checker.sv]
`timescale 1ns / 1ps
// tjpi_checker: port-level checks of the pi position controller, bound to
// the top level; depends on tjpi_pkg
module tjpi_checker
    import tjpi_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [JOINTS*SPEED_W-1:0]  m_tdata
);

    // a held result keeps its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after an input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !m_tvalid)
        else $error("input taken while an item is at work");

    // no new input while a result waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // every setpoint stays within the output clamp
    for (genvar j = 0; j < JOINTS; j++) begin : g_lane
        assert property (@(posedge aclk) disable iff (!aresetn)
            m_tvalid |-> ($signed(m_tdata[j*SPEED_W +: SPEED_W]) <= SPEED_LIMIT)
                      && ($signed(m_tdata[j*SPEED_W +: SPEED_W]) >= -SPEED_LIMIT))
            else $error("setpoint outside the clamp");
    end

endmodule

bind three_joint_pi_position_controller tjpi_checker #(.JOINTS(JOINTS)) u_tjpi_checker (.*);

[verif/tjpi_tb_pkg.sv]
`timescale 1ns / 1ps
// tjpi_tb_pkg: register index names shared by the testbench top and the
// speed checker of the three-joint pi position controller; no dependencies
package tjpi_tb_pkg;

    typedef enum logic [2:0] {
        REG_KP1,
        REG_KP2,
        REG_KP3,
        REG_KI1,
        REG_KI2,
        REG_KI3,
        REG_PERIOD,
        REG_REVERSE
    } cfg_reg_t;

    localparam int REG_COUNT = REG_REVERSE + 1;

endpackage

[verif/tjpi_speed_checker.sv]
`timescale 1ns / 1ps
// tjpi_speed_checker: watches the sample, speed and register ports, predicts
// the speed setpoints of every sample and compares them per joint
// depends on tjpi_pkg and tjpi_tb_pkg
module tjpi_speed_checker
    import tjpi_pkg::*;
    import tjpi_tb_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [2*JOINTS_DEF*POS_W-1:0]     s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [JOINTS_DEF*SPEED_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_addr,
    input  logic [CFG_DATA_W-1:0]             cfg_wdata,
    output int                                fail_count,
    output int                                pending_count
);

    logic [GAIN_W-1:0]     kp_q8 [JOINTS_DEF];
    logic [GAIN_W-1:0]     ki_q8 [JOINTS_DEF];
    logic [GAIN_W-1:0]     period_q16;
    logic [JOINTS_DEF-1:0] rev_mask;
    longint                integ [JOINTS_DEF];

    logic [JOINTS_DEF*SPEED_W-1:0] speeds_due [$];
    int fails = 0;

    function automatic longint saturate(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // advances the integrators and returns the setpoints for one sample
    function automatic logic [JOINTS_DEF*SPEED_W-1:0] pi_speeds(
        input logic [2*JOINTS_DEF*POS_W-1:0] positions
    );
        logic [JOINTS_DEF*SPEED_W-1:0] speeds;
        longint err;
        longint acc;
        longint spd;
        for (int j = 0; j < JOINTS_DEF; j++) begin
            err = longint'($signed(positions[j*POS_W +: POS_W]))
                - longint'($signed(positions[(JOINTS_DEF+j)*POS_W +: POS_W]));
            integ[j] = saturate(integ[j] + ((err * longint'(period_q16)) >>> 16),
                                INTEG_LIMIT);
            acc = err * longint'(kp_q8[j]) + integ[j] * longint'(ki_q8[j]);
            spd = saturate(acc >>> 8, SPEED_LIMIT);
            if (rev_mask[j])
                spd = -spd;
            speeds[j*SPEED_W +: SPEED_W] = spd[SPEED_W-1:0];
        end
        return speeds;
    endfunction

    task automatic flag(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    always @(posedge aclk) begin : watch
        logic [JOINTS_DEF*SPEED_W-1:0] want;
        if (!aresetn) begin
            for (int j = 0; j < JOINTS_DEF; j++) begin
                kp_q8[j] = KP_RESET;
                ki_q8[j] = KI_RESET;
                integ[j] = 0;
            end
            period_q16 = PERIOD_RESET;
            rev_mask   = REVERSE_RESET[JOINTS_DEF-1:0];
            speeds_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_KP1, REG_KP2, REG_KP3: kp_q8[2'(cfg_addr - REG_KP1)] = cfg_wdata;
                    REG_KI1, REG_KI2, REG_KI3: ki_q8[2'(cfg_addr - REG_KI1)] = cfg_wdata;
                    REG_PERIOD:                period_q16 = cfg_wdata;
                    REG_REVERSE:               rev_mask = cfg_wdata[JOINTS_DEF-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                speeds_due.push_back(pi_speeds(s_tdata));
            if (m_tvalid && m_tready) begin
                if (speeds_due.size() == 0) begin
                    flag("speed transfer with no sample outstanding");
                end else begin
                    want = speeds_due.pop_front();
                    for (int j = 0; j < JOINTS_DEF; j++) begin
                        if (m_tdata[j*SPEED_W +: SPEED_W] !== want[j*SPEED_W +: SPEED_W])
                            flag($sformatf("speed_joint%0d got %0d want %0d", j + 1,
                                 $signed(m_tdata[j*SPEED_W +: SPEED_W]),
                                 $signed(want[j*SPEED_W +: SPEED_W])));
                    end
                end
            end
        end
        pending_count <= speeds_due.size();
        fail_count    <= fails;
    end

endmodule

[verif/tb_three_joint_pi_position_controller.sv]
`timescale 1ns / 1ps
// tb_three_joint_pi_position_controller: stimulus and verdict for the
// three-joint pi position controller; checking lives in tjpi_speed_checker
// depends on tjpi_pkg, tjpi_tb_pkg, tjpi_speed_checker and the block itself
module tb_three_joint_pi_position_controller;
    import tjpi_pkg::*;
    import tjpi_tb_pkg::*;

    localparam int SAMPLE_W = 2 * JOINTS_DEF * POS_W;
    localparam int SPEEDS_W = JOINTS_DEF * SPEED_W;

    // handy q16.16 positions
    localparam logic [POS_W-1:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN  = 32'h8000_0000;
    localparam logic [POS_W-1:0] POS_ZERO = 32'h0000_0000;
    localparam logic [POS_W-1:0] SPD_EDGE = SPEED_LIMIT;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SPEEDS_W-1:0]   m_tdata;
    logic                  cfg_we    = 1'b0;
    cfg_reg_t              cfg_addr  = REG_KP1;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fails;
    int pending;

    // idle odds in percent per side, changed per phase
    int gap_odds   = 0;
    int stall_odds = 0;

    // register image written as a whole by load_settings
    logic [CFG_DATA_W-1:0] setting [REG_COUNT];

    always #4 aclk = ~aclk;

    three_joint_pi_position_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    tjpi_speed_checker speed_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fails),
        .pending_count (pending)
    );

    // hard stop, several times the slowest legal run
    initial begin
        #4_000_000;
        $display("three_joint_pi_position_controller regression: fail");
        $finish;
    end

    // result side: ready most of the time, with randomly drawn stall bursts
    initial begin : ready_side
        forever begin
            if (aresetn && $urandom_range(1, 100) <= stall_odds) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // one sample transfer; valid stays high straight into the next sample
    // unless a gap burst is drawn
    task automatic push_sample(input logic [SAMPLE_W-1:0] positions);
        if ($urandom_range(1, 100) <= gap_odds) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= positions;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // targets first, measured positions after, joint 1 lowest
    task automatic send_joints(input logic [POS_W-1:0] t1, t2, t3, m1, m2, m3);
        push_sample({m3, m2, m1, t3, t2, t1});
    endtask

    // drop valid and wait until every speed transfer has come back; the
    // block is idle then, since each sample gives exactly one result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    // back-to-back register writes, we stays high across the burst
    task automatic load_settings();
        for (int i = 0; i < REG_COUNT; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= cfg_reg_t'(i);
            cfg_wdata <= setting[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return CFG_DATA_W'($urandom_range(0, 512));   // up to 2.0
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_period();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return CFG_DATA_W'($urandom_range(1, 2000));  // up to about 30 ms
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // {measured, target} for one joint; mostly moderate errors so the
    // integrator moves through its range instead of sitting at a limit
    function automatic logic [2*POS_W-1:0] joint_pair();
        logic [POS_W-1:0] meas;
        logic [POS_W-1:0] tgt;
        meas = $urandom();
        case ($urandom_range(0, 9))
            0, 1:    tgt = $urandom();
            2: begin
                if ($urandom_range(0, 1)) begin
                    tgt  = POS_MAX;
                    meas = POS_MIN;
                end else begin
                    tgt  = POS_MIN;
                    meas = POS_MAX;
                end
            end
            3:       tgt = meas;
            4, 5, 6: tgt = meas + $urandom_range(0, 1 << 21) - (1 << 20);   // +-16 deg
            default: tgt = meas + $urandom_range(0, 1 << 25) - (1 << 24);   // +-256 deg
        endcase
        return {meas, tgt};
    endfunction

    initial begin : stimulus
        logic [SAMPLE_W-1:0]  positions;
        logic [2*POS_W-1:0]   pair;
        int                   burst;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed, reset gains: kp 1.0, ki 0, period ~10 ms, joint 3 reversed
        send_joints(POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);
        // widest positive and negative errors, then zero errors at the extremes; no wrap in the difference
        send_joints(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
        send_joints(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
        send_joints(POS_MAX, POS_MIN, POS_MAX, POS_MAX, POS_MIN, POS_MAX);
        // right at and one lsb past the speed clamp
        send_joints(SPD_EDGE, SPD_EDGE + 1, -SPD_EDGE, POS_ZERO, POS_ZERO, POS_ZERO);
        // one-lsb errors of both signs, floor rounding
        send_joints(32'h0000_0001, POS_ZERO, 32'hFFFF_FFFF, POS_ZERO, 32'h0000_0001,
                    POS_ZERO);
        send_joints(32'h0005_8000, 32'hFFFC_C000, 32'h0064_0000, 32'hFFFE_0000,
                    32'h0007_0000, POS_ZERO);

        // zero period: integrators hold, output is kp times the error plus ki
        // times the held value; reverse mask written with junk above its three bits
        drain();
        setting[REG_KP1]     = '0;
        setting[REG_KP2]     = 16'd1;
        setting[REG_KP3]     = '1;
        setting[REG_KI1]     = '1;
        setting[REG_KI2]     = '1;
        setting[REG_KI3]     = '1;
        setting[REG_PERIOD]  = '0;
        setting[REG_REVERSE] = 16'hFFF9;
        load_settings();
        send_joints(POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO, POS_ZERO);
        send_joints(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
        send_joints(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);

        // longest period: drive the integrators into both clamps
        drain();
        setting[REG_KP1]     = KP_RESET;
        setting[REG_KP2]     = '0;
        setting[REG_KP3]     = KP_RESET;
        setting[REG_KI1]     = '1;
        setting[REG_KI2]     = 16'd256;
        setting[REG_KI3]     = '1;
        setting[REG_PERIOD]  = '1;
        setting[REG_REVERSE] = 16'hABC2;
        load_settings();
        repeat (3) send_joints(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
        repeat (3) send_joints(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
        send_joints(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, POS_ZERO, POS_ZERO,
                    POS_ZERO);

        // random phases, each with its own register setting
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: begin
                    // everything at its low end
                    foreach (setting[i]) setting[i] = '0;
                    burst = 40;
                end
                1: begin
                    // everything at its high end
                    foreach (setting[i]) setting[i] = '1;
                    burst = 40;
                end
                default: begin
                    setting[REG_KP1]     = pick_gain();
                    setting[REG_KP2]     = pick_gain();
                    setting[REG_KP3]     = pick_gain();
                    setting[REG_KI1]     = pick_gain();
                    setting[REG_KI2]     = pick_gain();
                    setting[REG_KI3]     = pick_gain();
                    setting[REG_PERIOD]  = pick_period();
                    setting[REG_REVERSE] = CFG_DATA_W'($urandom_range(0, 65535));
                    burst = 90;
                end
            endcase
            // phase 3 runs without idling, the last phase too
            if (ph == 3 || ph == 7) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                gap_odds   = $urandom_range(10, 40);
                stall_odds = $urandom_range(10, 40);
            end
            load_settings();
            repeat (burst) begin
                for (int j = 0; j < JOINTS_DEF; j++) begin
                    pair = joint_pair();
                    positions[j*POS_W +: POS_W]              = pair[POS_W-1:0];
                    positions[(JOINTS_DEF+j)*POS_W +: POS_W] = pair[2*POS_W-1:POS_W];
                end
                push_sample(positions);
            end
        end

        drain();
        if (fails == 0)
            $display("three_joint_pi_position_controller regression: pass");
        else
            $display("three_joint_pi_position_controller regression: fail");
        $finish;
    end

endmodule

[three_joint_pi_position_controller.f]
sv/tjpi_pkg.sv
sv/three_joint_pi_position_controller.sv
sv/tjpi_checker.sv
verif/tjpi_tb_pkg.sv
verif/tjpi_speed_checker.sv
verif/tb_three_joint_pi_position_controller.sv
